>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("property violated");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("property violated");

`endif

>>> rtl/core/mdlr_pkg.sv
package mdlr_pkg;

    localparam int VALUE_W   = 32;
    localparam int DIM_W     = 7;
    localparam int CFG_IDX_W = 1;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

    // Item operation codes
    localparam logic OP_LOAD_ITEM = 1'b0;
    localparam logic OP_READ_ITEM = 1'b1;

    typedef struct packed {
        logic                      op;
        logic signed [VALUE_W-1:0] value;
    } mdlr_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_res;
        logic [DIM_W-1:0]          kept_rows;
        logic [DIM_W-1:0]          kept_cols;
        logic                      row_end;
        logic                      last;
        logic                      valid_res;
    } mdlr_result_t;

    // Datapath commands issued by the controller
    typedef enum logic [4:0] {
        DP_NONE,
        DP_LOAD,
        DP_SEL_INIT,
        DP_ROW_KEEP,
        DP_ROW_FETCH,
        DP_ROW_ELEM,
        DP_ROW_NEXT,
        DP_ROW_DROP,
        DP_ROW_STEP,
        DP_COL_INIT,
        DP_COL_KEEP,
        DP_COL_FETCH,
        DP_COL_DROP,
        DP_COL_ROW_FETCH,
        DP_COL_ELEM,
        DP_COL_NEXT,
        DP_COL_ROW_STEP,
        DP_READ_FETCH,
        DP_READ_ELEM,
        DP_READ_OUT,
        DP_READ_EMPTY
    } mdlr_cmd_t;

    typedef struct packed {
        logic reading;
        logic row_done;
        logic row_cand_end;
        logic col_done;
        logic col_cand_end;
        logic col_rows_end;
        logic elem_eq;
        logic last_col;
        logic past_end;
    } mdlr_status_t;

endpackage

>>> rtl/core/mdlr_ctrl.sv
module mdlr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   item_op,
    input  mdlr_pkg::mdlr_status_t status,
    output mdlr_pkg::mdlr_cmd_t    cmd,
    output logic                   busy
);
    import mdlr_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE       = 13'b0000000000001,
        S_ROW_TEST   = 13'b0000000000010,
        S_ROW_ELEM   = 13'b0000000000100,
        S_ROW_CMP    = 13'b0000000001000,
        S_COL_TEST   = 13'b0000000010000,
        S_COL_ROW    = 13'b0000000100000,
        S_COL_ELEM   = 13'b0000001000000,
        S_COL_CMP    = 13'b0000010000000,
        S_READ_FETCH = 13'b0000100000000,
        S_READ_ELEM  = 13'b0001000000000,
        S_READ_OUT   = 13'b0010000000000,
        S_SPARE_A    = 13'b0100000000000,
        S_SPARE_B    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = DP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (item_op == OP_LOAD_ITEM)
                    begin
                        cmd = DP_LOAD;
                    end
                    else if (status.reading)
                    begin
                        state_next = S_READ_FETCH;
                    end
                    else
                    begin
                        cmd        = DP_SEL_INIT;
                        state_next = S_ROW_TEST;
                    end
                end
            end
            S_ROW_TEST:
            begin
                if (status.row_done)
                begin
                    cmd        = DP_COL_INIT;
                    state_next = S_COL_TEST;
                end
                else if (status.row_cand_end)
                begin
                    cmd = DP_ROW_KEEP;
                end
                else
                begin
                    cmd        = DP_ROW_FETCH;
                    state_next = S_ROW_ELEM;
                end
            end
            S_ROW_ELEM:
            begin
                cmd        = DP_ROW_ELEM;
                state_next = S_ROW_CMP;
            end
            S_ROW_CMP:
            begin
                // mismatch: try the next kept row; full match: drop this row
                if (!status.elem_eq)
                begin
                    cmd        = DP_ROW_NEXT;
                    state_next = S_ROW_TEST;
                end
                else if (status.last_col)
                begin
                    cmd        = DP_ROW_DROP;
                    state_next = S_ROW_TEST;
                end
                else
                begin
                    cmd        = DP_ROW_STEP;
                    state_next = S_ROW_ELEM;
                end
            end
            S_COL_TEST:
            begin
                if (status.col_done)
                begin
                    state_next = S_READ_FETCH;
                end
                else if (status.col_cand_end)
                begin
                    cmd = DP_COL_KEEP;
                end
                else
                begin
                    cmd        = DP_COL_FETCH;
                    state_next = S_COL_ROW;
                end
            end
            S_COL_ROW:
            begin
                if (status.col_rows_end)
                begin
                    cmd        = DP_COL_DROP;
                    state_next = S_COL_TEST;
                end
                else
                begin
                    cmd        = DP_COL_ROW_FETCH;
                    state_next = S_COL_ELEM;
                end
            end
            S_COL_ELEM:
            begin
                cmd        = DP_COL_ELEM;
                state_next = S_COL_CMP;
            end
            S_COL_CMP:
            begin
                if (!status.elem_eq)
                begin
                    cmd        = DP_COL_NEXT;
                    state_next = S_COL_TEST;
                end
                else
                begin
                    cmd        = DP_COL_ROW_STEP;
                    state_next = S_COL_ROW;
                end
            end
            S_READ_FETCH:
            begin
                if (status.past_end)
                begin
                    cmd        = DP_READ_EMPTY;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd        = DP_READ_FETCH;
                    state_next = S_READ_ELEM;
                end
            end
            S_READ_ELEM:
            begin
                cmd        = DP_READ_ELEM;
                state_next = S_READ_OUT;
            end
            S_READ_OUT:
            begin
                cmd        = DP_READ_OUT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> rtl/core/mdlr_dp.sv
module mdlr_dp #(
    parameter int MAX_DIM = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mdlr_pkg::mdlr_cmd_t                  cmd,
    input  logic signed [mdlr_pkg::VALUE_W-1:0]  load_value,
    input  logic                                 cfg_we,
    input  logic [mdlr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mdlr_pkg::DIM_W-1:0]           cfg_data,
    output mdlr_pkg::mdlr_status_t               status,
    output logic                                 done,
    output mdlr_pkg::mdlr_result_t               result
);
    import mdlr_pkg::*;

    localparam int CW    = $clog2(MAX_DIM + 1);
    localparam int LAW   = $clog2(MAX_DIM);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    logic [DIM_W-1:0] rows_reg, rows_next;
    logic [DIM_W-1:0] cols_reg, cols_next;
    logic             phase_reg, phase_next;
    logic [NW-1:0]    load_cnt_reg, load_cnt_next;
    logic [NW-1:0]    rbase_reg, rbase_next;
    logic [CW-1:0]    r_reg, r_next;
    logic [CW-1:0]    c_reg, c_next;
    logic [CW-1:0]    j_reg, j_next;
    logic [CW-1:0]    i_reg, i_next;
    logic [CW-1:0]    krc_reg, krc_next;
    logic [CW-1:0]    kcc_reg, kcc_next;
    logic [CW-1:0]    kr_reg, kr_next;
    logic [CW-1:0]    kc_reg, kc_next;
    logic             done_reg, done_next;
    mdlr_result_t     res_reg, res_next;

    // Element store and the lists of kept rows (base addresses) and columns
    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic [NW-1:0]             row_list [MAX_DIM];
    logic [CW-1:0]             col_list [MAX_DIM];

    logic signed [VALUE_W-1:0] rd_a_reg, rd_b_reg;
    logic                      ok_a_reg, ok_b_reg;
    logic [NW-1:0]             row_rd_reg;
    logic [CW-1:0]             col_rd_reg;

    logic [CW-1:0]             nr, nc;
    logic [NW-1:0]             total;
    logic [NW-1:0]             addr_a, addr_b, wr_addr;
    logic                      wr_en;
    logic [CW-1:0]             row_ra, col_ra;
    logic                      row_re, col_re;
    logic signed [VALUE_W-1:0] a_eff, b_eff;
    logic                      kc_last, kr_last;

    function automatic logic [CW-1:0] eff_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
            return CW'(1);
        else if (int'(v) > MAX_DIM)
            return CW'(MAX_DIM);
        else
            return CW'(v);
    endfunction

    assign nr    = eff_dim(rows_reg);
    assign nc    = eff_dim(cols_reg);
    assign total = NW'(nr) * NW'(nc);

    assign addr_a = ((cmd == DP_ROW_ELEM) ? rbase_reg : row_rd_reg)
                  + ((cmd == DP_READ_ELEM) ? NW'(col_rd_reg) : NW'(c_reg));
    assign addr_b = row_rd_reg
                  + ((cmd == DP_ROW_ELEM) ? NW'(c_reg) : NW'(col_rd_reg));

    // A load after reading restarts the matrix at element zero
    assign wr_addr = phase_reg ? '0 : load_cnt_reg;
    assign wr_en   = (cmd == DP_LOAD) && (phase_reg || (load_cnt_reg < total));

    assign row_re = (cmd == DP_ROW_FETCH) || (cmd == DP_COL_ROW_FETCH)
                 || (cmd == DP_READ_FETCH);
    assign row_ra = (cmd == DP_ROW_FETCH) ? j_reg
                  : (cmd == DP_COL_ROW_FETCH) ? i_reg : kr_reg;
    assign col_re = (cmd == DP_COL_FETCH) || (cmd == DP_READ_FETCH);
    assign col_ra = (cmd == DP_COL_FETCH) ? j_reg : kc_reg;

    // Elements beyond the fill count read as zero
    assign a_eff = ok_a_reg ? rd_a_reg : '0;
    assign b_eff = ok_b_reg ? rd_b_reg : '0;

    assign kc_last = (kc_reg == kcc_reg - CW'(1));
    assign kr_last = (kr_reg == krc_reg - CW'(1));

    always_comb
    begin
        status.reading      = phase_reg;
        status.row_done     = (r_reg == nr);
        status.row_cand_end = (j_reg == krc_reg);
        status.col_done     = (c_reg == nc);
        status.col_cand_end = (j_reg == kcc_reg);
        status.col_rows_end = (i_reg == krc_reg);
        status.elem_eq      = (a_eff == b_eff);
        status.last_col     = (c_reg == nc - CW'(1));
        status.past_end     = (kr_reg == krc_reg);
    end

    always_comb
    begin
        rows_next     = rows_reg;
        cols_next     = cols_reg;
        phase_next    = phase_reg;
        load_cnt_next = load_cnt_reg;
        rbase_next    = rbase_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        j_next        = j_reg;
        i_next        = i_reg;
        krc_next      = krc_reg;
        kcc_next      = kcc_reg;
        kr_next       = kr_reg;
        kc_next       = kc_reg;
        done_next     = 1'b0;
        res_next      = res_reg;

        case (cmd)
            DP_LOAD:
            begin
                phase_next = 1'b0;
                if (wr_en)
                begin
                    load_cnt_next = wr_addr + NW'(1);
                end
            end
            DP_SEL_INIT:
            begin
                phase_next = 1'b1;
                r_next     = '0;
                rbase_next = '0;
                krc_next   = '0;
                j_next     = '0;
                kr_next    = '0;
                kc_next    = '0;
            end
            DP_ROW_KEEP:
            begin
                krc_next   = krc_reg + CW'(1);
                r_next     = r_reg + CW'(1);
                rbase_next = rbase_reg + NW'(nc);
                j_next     = '0;
            end
            DP_ROW_FETCH:
            begin
                c_next = '0;
            end
            DP_ROW_NEXT:
            begin
                j_next = j_reg + CW'(1);
            end
            DP_ROW_DROP:
            begin
                r_next     = r_reg + CW'(1);
                rbase_next = rbase_reg + NW'(nc);
                j_next     = '0;
            end
            DP_ROW_STEP:
            begin
                c_next = c_reg + CW'(1);
            end
            DP_COL_INIT:
            begin
                c_next   = '0;
                kcc_next = '0;
                j_next   = '0;
            end
            DP_COL_KEEP:
            begin
                kcc_next = kcc_reg + CW'(1);
                c_next   = c_reg + CW'(1);
                j_next   = '0;
            end
            DP_COL_FETCH:
            begin
                i_next = '0;
            end
            DP_COL_DROP:
            begin
                c_next = c_reg + CW'(1);
                j_next = '0;
            end
            DP_COL_NEXT:
            begin
                j_next = j_reg + CW'(1);
            end
            DP_COL_ROW_STEP:
            begin
                i_next = i_reg + CW'(1);
            end
            DP_READ_OUT:
            begin
                done_next          = 1'b1;
                res_next.value_res = a_eff;
                res_next.kept_rows = DIM_W'(krc_reg);
                res_next.kept_cols = DIM_W'(kcc_reg);
                res_next.row_end   = kc_last;
                res_next.last      = kc_last && kr_last;
                res_next.valid_res = 1'b1;
                if (kc_last)
                begin
                    kc_next = '0;
                    kr_next = kr_reg + CW'(1);
                end
                else
                begin
                    kc_next = kc_reg + CW'(1);
                end
            end
            DP_READ_EMPTY:
            begin
                done_next          = 1'b1;
                res_next.value_res = '0;
                res_next.kept_rows = DIM_W'(krc_reg);
                res_next.kept_cols = DIM_W'(kcc_reg);
                res_next.row_end   = 1'b0;
                res_next.last      = 1'b0;
                res_next.valid_res = 1'b0;
            end
            default:
            begin
            end
        endcase

        // Any register write returns the block to loading
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS: rows_next = cfg_data;
                REG_COLS: cols_next = cfg_data;
                default:
                begin
                end
            endcase
            phase_next    = 1'b0;
            load_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg     <= DIM_W'(1);
            cols_reg     <= DIM_W'(1);
            phase_reg    <= 1'b0;
            load_cnt_reg <= '0;
            rbase_reg    <= '0;
            r_reg        <= '0;
            c_reg        <= '0;
            j_reg        <= '0;
            i_reg        <= '0;
            krc_reg      <= '0;
            kcc_reg      <= '0;
            kr_reg       <= '0;
            kc_reg       <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            rows_reg     <= rows_next;
            cols_reg     <= cols_next;
            phase_reg    <= phase_next;
            load_cnt_reg <= load_cnt_next;
            rbase_reg    <= rbase_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            j_reg        <= j_next;
            i_reg        <= i_next;
            krc_reg      <= krc_next;
            kcc_reg      <= kcc_next;
            kr_reg       <= kr_next;
            kc_reg       <= kc_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[AW-1:0]] <= load_value;
        end
        rd_a_reg <= mem[addr_a[AW-1:0]];
        rd_b_reg <= mem[addr_b[AW-1:0]];
        ok_a_reg <= (addr_a < load_cnt_reg);
        ok_b_reg <= (addr_b < load_cnt_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd == DP_ROW_KEEP)
        begin
            row_list[krc_reg[LAW-1:0]] <= rbase_reg;
        end
        if (row_re)
        begin
            row_rd_reg <= row_list[row_ra[LAW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == DP_COL_KEEP)
        begin
            col_list[kcc_reg[LAW-1:0]] <= c_reg;
        end
        if (col_re)
        begin
            col_rd_reg <= col_list[col_ra[LAW-1:0]];
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> rtl/core/matrix_duplicate_line_removal.sv
// Removes duplicate rows, then duplicate columns (compared over the kept rows), from a
// rows-by-cols matrix loaded element by element in row-major order. A load transaction
// leaves busy low. A read transaction holds busy high through the fetch, element and
// output states, and the result shows on result for exactly one cycle with done high; it
// cannot be held off, so capture it when done is high. A read past the end of the result
// holds busy high in the fetch state only. The first read after loading first runs the
// selection pass over the element store, which has two read ports. The row pass compares
// each row with the kept rows and the column pass each column with the kept columns over
// the kept rows; a comparison ends at the first element that differs. Write rows or cols
// only while busy is low; either write starts a new matrix.
module matrix_duplicate_line_removal #(
    parameter int MAX_DIM = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  mdlr_pkg::mdlr_item_t           item,
    output logic                           done,
    output mdlr_pkg::mdlr_result_t         result,
    input  logic                           cfg_we,
    input  logic [mdlr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mdlr_pkg::DIM_W-1:0]     cfg_data
);
    import mdlr_pkg::*;

    mdlr_cmd_t    cmd;
    mdlr_status_t status;

    mdlr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item_op (item.op),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    mdlr_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .load_value (item.value),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .status     (status),
        .done       (done),
        .result     (result)
    );

endmodule

>>> rtl/core/mdlr_checker.sv
`include "assert_macros.svh"

module mdlr_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input mdlr_pkg::mdlr_item_t   item,
    input logic                   done,
    input mdlr_pkg::mdlr_result_t result
);
    import mdlr_pkg::*;

    // a result only ever follows a busy cycle
    `ASSERT_IMPLIES(a_done_after_busy, done, $past(busy))

    // a load transaction produces no result
    `ASSERT_NEXT(a_load_silent, start && !busy && (item.op == OP_LOAD_ITEM), !done)

    // a read transaction occupies the block
    `ASSERT_NEXT(a_read_busy, start && !busy && (item.op == OP_READ_ITEM), busy)

    // a read past the end carries no element and no marks
    `ASSERT_IMPLIES(a_empty_clean, done && !result.valid_res,
        (result.value_res == '0) && !result.row_end && !result.last)

    // the final element also closes its row
    `ASSERT_IMPLIES(a_last_ends_row, done && result.last,
        result.row_end && result.valid_res)

endmodule

bind matrix_duplicate_line_removal mdlr_checker u_checker (.*);
